// ===== hdl/u8v_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

  // largest unit limit the block honors
  localparam int UNIT_LIMIT_MAX = 4095;

  // widths
  localparam int LIMIT_W = 12;
  localparam int COUNT_W = 13;
  localparam int CODE_W  = 21;

  // register indexes of the configuration port
  localparam logic REG_MAX_UNITS     = 1'b0;
  localparam logic REG_TEXT_REQUIRED = 1'b1;

  // byte classes
  localparam logic [7:0] ASCII_MIN = 8'h20;
  localparam logic [7:0] ASCII_DEL = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // code point bounds
  localparam logic [CODE_W-1:0] MIN_2BYTE = 21'h00080;
  localparam logic [CODE_W-1:0] MIN_3BYTE = 21'h00800;
  localparam logic [CODE_W-1:0] MIN_4BYTE = 21'h10000;
  localparam logic [CODE_W-1:0] BMP_MAX   = 21'h0FFFF;
  localparam logic [CODE_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CODE_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CODE_W-1:0] SURR_HI   = 21'h0DFFF;

  // sequence length classes (continuation bytes of the sequence)
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last;
    logic       empty_text;
  } in_item_t;

  typedef struct packed {
    logic               text_valid;
    logic [COUNT_W-1:0] unit_count;
  } out_item_t;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]         pending_continuations;
    logic [CODE_W-1:0]  code_accumulator;
    logic [1:0]         length_class;
    logic [COUNT_W-1:0] unit_counter;
    logic               failed_flag;
  } text_state_t;

endpackage

`default_nettype wire

// ===== hdl/u8v_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8v_step (
  input  u8v_pkg::text_state_t        st,
  input  u8v_pkg::in_item_t           item,
  input  logic [u8v_pkg::LIMIT_W-1:0] max_units,
  input  logic                        text_required,
  output u8v_pkg::text_state_t        st_next,
  output logic                        has_result,
  output u8v_pkg::out_item_t          result
);
  import u8v_pkg::*;

  logic [7:0]         b;
  logic [LIMIT_W-1:0] lim;
  logic [COUNT_W-1:0] lim_plus;
  logic [CODE_W-1:0]  acc_shift;
  logic [1:0]         pend_dec;
  logic [CODE_W-1:0]  minimum;
  logic               add_en;
  logic [1:0]         add_n;
  logic [COUNT_W-1:0] total;
  text_state_t        nx;

  assign b = item.byte_value;

  // limit clamp and saturation value
  always_comb begin
    if (max_units > LIMIT_W'(UNIT_LIMIT_MAX)) begin
      lim = LIMIT_W'(UNIT_LIMIT_MAX);
    end else begin
      lim = max_units;
    end
    lim_plus = {1'b0, lim} + COUNT_W'(1);
  end

  // continuation assembly
  assign acc_shift = {st.code_accumulator[CODE_W-7:0], b[5:0]};
  assign pend_dec  = st.pending_continuations - 2'd1;

  // overlong minimum for the finished sequence
  always_comb begin
    unique case (st.length_class)
      LEN_TWO:   minimum = MIN_2BYTE;
      LEN_THREE: minimum = MIN_3BYTE;
      LEN_FOUR:  minimum = MIN_4BYTE;
      default:   minimum = MIN_4BYTE;
    endcase
  end

  // byte decode
  always_comb begin
    nx     = st;
    add_en = 1'b0;
    add_n  = 2'd1;
    if (!st.failed_flag) begin
      if (st.pending_continuations == 2'd0) begin
        if (!b[7]) begin
          if (b < ASCII_MIN || b == ASCII_DEL) begin
            nx.failed_flag = 1'b1;
          end else begin
            add_en = 1'b1;
          end
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          nx.code_accumulator      = CODE_W'(b[4:0]);
          nx.pending_continuations = 2'd1;
          nx.length_class          = LEN_TWO;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          nx.code_accumulator      = CODE_W'(b[3:0]);
          nx.pending_continuations = 2'd2;
          nx.length_class          = LEN_THREE;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          nx.code_accumulator      = CODE_W'(b[2:0]);
          nx.pending_continuations = 2'd3;
          nx.length_class          = LEN_FOUR;
        end else begin
          nx.failed_flag = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        nx.failed_flag = 1'b1;
      end else begin
        nx.code_accumulator      = acc_shift;
        nx.pending_continuations = pend_dec;
        if (pend_dec == 2'd0) begin
          if (acc_shift < minimum || acc_shift > CP_MAX ||
              (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
            nx.failed_flag = 1'b1;
          end else begin
            add_en = 1'b1;
            add_n  = (acc_shift > BMP_MAX) ? 2'd2 : 2'd1;
          end
        end
      end
    end

    // utf-16 unit count with saturation
    total = st.unit_counter + COUNT_W'(add_n);
    if (add_en) begin
      if (total > {1'b0, lim}) begin
        nx.unit_counter = lim_plus;
        nx.failed_flag  = 1'b1;
      end else begin
        nx.unit_counter = total;
      end
    end
  end

  // closing item and state clear
  always_comb begin
    st_next    = nx;
    has_result = 1'b0;
    result     = '0;
    if (item.empty_text) begin
      has_result        = 1'b1;
      result.text_valid = !text_required;
      result.unit_count = '0;
      st_next           = '0;
    end else if (item.is_last) begin
      has_result        = 1'b1;
      result.text_valid = !(nx.failed_flag || (nx.pending_continuations != 2'd0));
      result.unit_count = nx.unit_counter;
      st_next           = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8_validator_utf16_length_limit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a closing request's result is decoded from the input register and held in
// the result register until it is taken
// throughput: one byte per cycle unless a closing byte waits on a stalled
// result register; the decode between the two registers is combinational
// reset: synchronous, clears the pipeline and the decoder state; max_units
// returns to 180 and text_required to 1
module utf8_validator_utf16_length_limit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  u8v_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output u8v_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [u8v_pkg::LIMIT_W-1:0] cfg_data
);
  import u8v_pkg::*;

  logic               s1_valid;
  in_item_t           s1_item;
  text_state_t        st;
  text_state_t        st_next;
  logic               has_result;
  out_item_t          result;
  logic               s1_go;
  logic [LIMIT_W-1:0] max_units;
  logic               text_required;

  u8v_step u_step (
    .st            (st),
    .item          (s1_item),
    .max_units     (max_units),
    .text_required (text_required),
    .st_next       (st_next),
    .has_result    (has_result),
    .result        (result)
  );

  // stage advance: a result needs a free or draining output register
  assign s1_go     = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units     <= LIMIT_W'(180);
      text_required <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_UNITS) begin
        max_units <= cfg_data;
      end else if (cfg_index == REG_TEXT_REQUIRED) begin
        text_required <= cfg_data[0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      out_data <= result;
    end
  end

  // state is clean after a closing request
  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    s1_go && has_result |=> st == '0)
    else $error("decoder state not cleared after closing request");

  // a failure sticks until the text closes
  a_failed_sticks: assert property (@(posedge clk) disable iff (rst)
    st.failed_flag && !(s1_go && has_result) |=> st.failed_flag)
    else $error("failure flag dropped mid-text");

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && has_result && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result path is blocked");

endmodule

`default_nettype wire

// ===== bench/utf8_validator_utf16_length_limit_tb.sv =====
`timescale 1ns / 1ps

module utf8_validator_utf16_length_limit_tb;
  import u8v_pkg::*;

  localparam int PERIOD        = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int PHASE_ITEMS   = 230;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;

  // one row of the directed part: a register write or a request
  typedef struct packed {
    logic               is_cfg;
    logic               cfg_idx;
    logic [LIMIT_W-1:0] cfg_val;
    in_item_t           item;
    logic               typed;
    out_item_t          want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_MAX_UNITS;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // verdict predictor state and its copy of the registers
  logic [1:0]         pend_cont;
  logic [CODE_W-1:0]  code_acc;
  logic [1:0]         len_class;
  logic [COUNT_W-1:0] unit_cnt;
  logic               text_failed;
  logic [LIMIT_W-1:0] unit_cap_reg = 12'd180;
  logic               empty_rejected_reg = 1'b1;

  out_item_t text_results_q[$];
  dir_row_t  stim_rows[$];
  in_item_t  text_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic stall_ask = 1'b0;
  logic stall_taken = 1'b0;
  int hold_left = 0;

  int phase_cap[NUM_PHASES]    = '{4095, 3, 0, 37, 180, 12};
  int phase_reject[NUM_PHASES] = '{0, 1, 0, 1, 1, 0};
  int phase_send[NUM_PHASES]   = '{8, 8, 55, 55, 0, 0};
  int phase_recv[NUM_PHASES]   = '{55, 55, 8, 8, 0, 0};

  utf8_validator_utf16_length_limit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // decoder state back to the start of a text
  function automatic void clear_decoder();
    pend_cont   = '0;
    code_acc    = '0;
    len_class   = LEN_NONE;
    unit_cnt    = '0;
    text_failed = 1'b0;
  endfunction

  // utf-16 units with saturation just past the limit
  function automatic void add_units(int n);
    int cap;
    int total;
    cap = (unit_cap_reg > UNIT_LIMIT_MAX) ? UNIT_LIMIT_MAX : int'(unit_cap_reg);
    total = int'(unit_cnt) + n;
    if (total > cap) begin
      total = cap + 1;
      text_failed = 1'b1;
    end
    unit_cnt = total[COUNT_W-1:0];
  endfunction

  // strict utf-8 decode of one byte
  function automatic void decode_byte(logic [7:0] b);
    logic [CODE_W-1:0] floor_cp;
    if (text_failed) return;
    if (pend_cont == 0) begin
      if (!b[7]) begin
        if (b < ASCII_MIN || b == ASCII_DEL) text_failed = 1'b1;
        else add_units(1);
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        code_acc  = {16'd0, b[4:0]};
        pend_cont = 2'd1;
        len_class = LEN_TWO;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        code_acc  = {17'd0, b[3:0]};
        pend_cont = 2'd2;
        len_class = LEN_THREE;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        code_acc  = {18'd0, b[2:0]};
        pend_cont = 2'd3;
        len_class = LEN_FOUR;
      end else begin
        text_failed = 1'b1;
      end
    end else if ((b & CONT_MASK) != CONT_TAG) begin
      text_failed = 1'b1;
    end else begin
      code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
      pend_cont = pend_cont - 2'd1;
      if (pend_cont == 0) begin
        case (len_class)
          LEN_TWO:   floor_cp = MIN_2BYTE;
          LEN_THREE: floor_cp = MIN_3BYTE;
          default:   floor_cp = MIN_4BYTE;
        endcase
        if (code_acc < floor_cp || code_acc > CP_MAX ||
            (code_acc >= SURR_LO && code_acc <= SURR_HI))
          text_failed = 1'b1;
        else
          add_units((code_acc > BMP_MAX) ? 2 : 1);
      end
    end
  endfunction

  // verdict for one accepted request, if it closes a text
  function automatic void predict_verdict(input in_item_t it, output logic gives,
                                          output out_item_t res);
    gives = 1'b0;
    res   = '0;
    if (it.empty_text) begin
      clear_decoder();
      gives          = 1'b1;
      res.text_valid = ~empty_rejected_reg;
    end else begin
      decode_byte(it.byte_value);
      if (it.is_last) begin
        if (pend_cont != 0) text_failed = 1'b1;
        gives          = 1'b1;
        res.text_valid = ~text_failed;
        res.unit_count = unit_cnt;
        clear_decoder();
      end
    end
  endfunction

  // offer one request, hold it until taken, then log its verdict
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    logic      gives;
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(it, gives, res);
    if (gives) text_results_q = {text_results_q, (typed ? want : res)};
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] val);
    in_valid <= 1'b0;
    while (text_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_UNITS) unit_cap_reg = val;
    else empty_rejected_reg = val[0];
  endtask

  // directed rows
  function automatic void row_byte(logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.item.byte_value = b;
    stim_rows = {stim_rows, r};
  endfunction

  function automatic void row_close(logic [7:0] b, logic last, logic empty, logic typed,
                                    logic ok, int count);
    dir_row_t r;
    r = '0;
    r.item.byte_value = b;
    r.item.is_last    = last;
    r.item.empty_text = empty;
    r.typed           = typed;
    r.want.text_valid = ok;
    r.want.unit_count = count[COUNT_W-1:0];
    stim_rows = {stim_rows, r};
  endfunction

  function automatic void row_cfg(logic idx, logic [LIMIT_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    stim_rows = {stim_rows, r};
  endfunction

  function automatic void push_data(logic [7:0] b, logic last);
    in_item_t it;
    it.byte_value = b;
    it.is_last    = last;
    it.empty_text = 1'b0;
    text_bytes = {text_bytes, it};
  endfunction

  // one code point, well formed or deliberately broken, in its utf-8 form
  function automatic void put_code_point(logic broken);
    logic [1:0]        cls;
    logic [CODE_W-1:0] cp;
    int                r;
    r   = $urandom_range(5);
    cls = (r < 3) ? LEN_NONE : 2'(r - 2);
    case (cls)
      LEN_NONE: begin
        if (broken) cp = CODE_W'($urandom_range(1) ? ASCII_DEL : $urandom_range(8'h1F));
        else cp = CODE_W'($urandom_range(8'h7E, 8'h20));
        push_data(cp[7:0], 1'b0);
      end
      LEN_TWO: begin
        cp = CODE_W'(broken ? $urandom_range(8'h7F) : $urandom_range(12'h7FF, 12'h080));
        push_data({3'b110, cp[10:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b0);
      end
      LEN_THREE: begin
        if (broken)
          cp = CODE_W'($urandom_range(1) ? $urandom_range(12'h7FF)
                                         : $urandom_range(SURR_HI, SURR_LO));
        else begin
          cp = CODE_W'($urandom_range(16'hFFFF, 16'h0800));
          if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
        end
        push_data({4'b1110, cp[15:12]}, 1'b0);
        push_data({2'b10, cp[11:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b0);
      end
      default: begin
        if (broken)
          cp = CODE_W'($urandom_range(1) ? $urandom_range(16'hFFFF)
                                         : $urandom_range(21'h1FFFFF, 21'h110000));
        else cp = CODE_W'($urandom_range(CP_MAX, MIN_4BYTE));
        push_data({5'b11110, cp[20:18]}, 1'b0);
        push_data({2'b10, cp[17:12]}, 1'b0);
        push_data({2'b10, cp[11:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b0);
      end
    endcase
  endfunction

  // one random text: mostly well formed, some broken, some noise
  function automatic void build_text();
    int       kind;
    int       dmg;
    int       n_cp;
    int       pos;
    in_item_t tmp;
    text_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 6) begin
      tmp.byte_value = 8'($urandom_range(255));
      tmp.is_last    = 1'($urandom_range(1));
      tmp.empty_text = 1'b1;
      text_bytes = {text_bytes, tmp};
    end else begin
      if (kind < 12) begin
        n_cp = $urandom_range(6, 1);
        for (int i = 0; i < n_cp; i++)
          push_data(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
        n_cp = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        for (int i = 0; i < n_cp; i++)
          put_code_point(kind < 22 && $urandom_range(3) == 0);
      end
      // damage: cut off the end, corrupt one byte, or drop an empty mark in mid-text
      dmg = $urandom_range(99);
      pos = $urandom_range(text_bytes.size() - 1);
      if (dmg < 5 && text_bytes.size() > 1) begin
        void'(text_bytes.pop_back());
      end else if (dmg < 10) begin
        tmp = text_bytes[pos];
        tmp.byte_value = 8'($urandom_range(255));
        text_bytes[pos] = tmp;
      end else if (dmg < 13) begin
        tmp = text_bytes[pos];
        tmp.empty_text = 1'b1;
        text_bytes[pos] = tmp;
      end
      tmp = text_bytes[text_bytes.size() - 1];
      tmp.is_last = 1'b1;
      text_bytes[text_bytes.size() - 1] = tmp;
    end
  endfunction

  // receive side: check each verdict, pace out_ready, one long hold-off on request
  always @(posedge clk) begin : recv_side
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (text_results_q.size() == 0) begin
        $error("verdict with nothing expected: text_valid %0d unit_count %0d",
               out_data.text_valid, out_data.unit_count);
        mismatches++;
      end else begin
        want = text_results_q.pop_front();
        if (out_data.text_valid !== want.text_valid) begin
          $error("text_valid: expected %0d, got %0d", want.text_valid, out_data.text_valid);
          mismatches++;
        end
        if (out_data.unit_count !== want.unit_count) begin
          $error("unit_count: expected %0d, got %0d", want.unit_count, out_data.unit_count);
          mismatches++;
        end
      end
    end
    if (stall_ask && !stall_taken) begin
      stall_taken = 1'b1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("utf8_validator_utf16_length_limit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    // reset-time settings: limit 180, empty text rejected
    row_close(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 0);
    row_close(8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 1);
    row_close(8'h1F, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    row_close(ASCII_DEL, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // both marks: the byte is ignored
    row_close(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 0);
    row_close(8'hC1, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // overlong three-byte form
    row_byte(8'hE0);
    row_byte(8'h80);
    row_close(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // surrogate
    row_byte(8'hED);
    row_byte(8'hA0);
    row_close(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // above the last code point
    row_byte(8'hF4);
    row_byte(8'h90);
    row_byte(8'h80);
    row_close(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // cut off by the end of the text
    row_close(8'hC3, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // empty mark in mid-text drops the partial text
    row_byte(8'hC3);
    row_close(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 0);
    // bad continuation byte
    row_byte(8'hC3);
    row_close(8'h41, 1'b1, 1'b0, 1'b1, 1'b0, 0);
    // zero limit: count saturates at one; empty text now accepted
    row_cfg(REG_MAX_UNITS, 12'd0);
    row_cfg(REG_TEXT_REQUIRED, 12'd0);
    row_close(8'h41, 1'b1, 1'b0, 1'b1, 1'b0, 1);
    row_close(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 0);
    // four-byte form overruns a limit of one
    row_cfg(REG_MAX_UNITS, 12'd1);
    row_byte(8'hF0);
    row_byte(8'h9F);
    row_byte(8'h98);
    row_close(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 2);

    clear_decoder();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = phase_send[0];
    recv_idle_pct <= phase_recv[0];
    @(posedge clk);

    // directed part
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
      else send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
    end

    // random phases, each with its own limit, empty-text rule and pacing
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_MAX_UNITS, LIMIT_W'(phase_cap[p]));
      write_reg(REG_TEXT_REQUIRED, LIMIT_W'(phase_reject[p]));
      send_idle_pct = phase_send[p];
      recv_idle_pct <= phase_recv[p];
      if (p == 0) stall_ask <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_text();
        foreach (text_bytes[i]) send_item(text_bytes[i], 1'b0, '0);
        sent += text_bytes.size();
      end
    end

    in_valid <= 1'b0;
    while (text_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("utf8_validator_utf16_length_limit_tb: done, clean");
    else
      $display("utf8_validator_utf16_length_limit_tb: done, errors");
    $finish;
  end

endmodule
